/* sv/wsh_pkg.sv */
package wsh_pkg;

  // Stack geometry
  localparam int MAX_WINDOWS = 16;
  localparam int COORD_BITS  = 12;

  // Fixed field widths of the ports
  localparam int SLOT_W   = 5;
  localparam int ID_OUT_W = 5;
  localparam int CNT_W    = 5;
  localparam int APB_AW   = 3;
  localparam int APB_DW   = 32;

  // Position and window number width, wide enough to hold MAX_WINDOWS
  localparam int POS_W = $clog2(MAX_WINDOWS + 1);

  // Item command codes
  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_CLICK = 1'b1;

  // Register index of window_count
  localparam logic REG_WINDOW_COUNT = 1'b0;

  typedef logic [COORD_BITS-1:0] coord_t;
  typedef logic [POS_W-1:0]      pos_t;

  typedef struct packed {
    coord_t left;
    coord_t bottom;
    coord_t right;
    coord_t top;
  } rect_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load_we;
    logic point_we;
    logic search_en;
    logic shift_en;
  } wsh_cmd_t;

  // Controller states, one-hot
  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_SEARCH = 3'b010,
    ST_SHIFT  = 3'b100
  } wsh_state_e;

endpackage

/* sv/wsh_ctrl.sv */
module wsh_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              command_i,
  input  logic              out_ready_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  output wsh_pkg::wsh_cmd_t cmd_o
);
  import wsh_pkg::*;

  wsh_state_e state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       accept;

  // Take an item only when idle and the result slot is free or draining
  assign in_ready_o = (state_q == ST_IDLE) && (!out_valid_q || out_ready_i);
  assign accept     = in_valid_i && in_ready_o;

  // Next state and commands
  always_comb begin
    state_d       = state_q;
    cmd_o         = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (command_i == CMD_CLICK) begin
            cmd_o.point_we = 1'b1;
            state_d        = ST_SEARCH;
          end else begin
            cmd_o.load_we = 1'b1;
          end
        end
      end
      ST_SEARCH: begin
        cmd_o.search_en = 1'b1;
        state_d         = ST_SHIFT;
      end
      ST_SHIFT: begin
        cmd_o.shift_en = 1'b1;
        state_d        = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Hold the result valid until it is taken
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_o.shift_en) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

/* sv/wsh_dp.sv */
module wsh_dp (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  wsh_pkg::wsh_cmd_t              cmd_i,
  input  logic [wsh_pkg::CNT_W-1:0]      window_count_i,
  input  logic [wsh_pkg::SLOT_W-1:0]     slot_i,
  input  wsh_pkg::coord_t                left_i,
  input  wsh_pkg::coord_t                bottom_i,
  input  wsh_pkg::coord_t                right_i,
  input  wsh_pkg::coord_t                top_i,
  input  wsh_pkg::coord_t                point_x_i,
  input  wsh_pkg::coord_t                point_y_i,
  output logic                           hit_o,
  output logic [wsh_pkg::ID_OUT_W-1:0]   window_id_o
);
  import wsh_pkg::*;

  rect_t  rect_q [1:MAX_WINDOWS];
  pos_t   id_q   [1:MAX_WINDOWS];
  coord_t px_q, py_q;
  logic   found_q, found_d;
  pos_t   pos_q, pos_d;
  pos_t   n_top;
  logic   slot_ok;
  rect_t  load_rect;
  rect_t  saved_rect;
  pos_t   saved_id;
  logic   [MAX_WINDOWS:1] match;
  logic   hit_q;
  logic   [ID_OUT_W-1:0] win_id_q;

  // Top of the stack, saturated at the stack depth
  always_comb begin
    if (int'(window_count_i) > MAX_WINDOWS) begin
      n_top = POS_W'(MAX_WINDOWS);
    end else begin
      n_top = POS_W'(window_count_i);
    end
  end

  assign slot_ok   = (int'(slot_i) >= 1) && (int'(slot_i) <= MAX_WINDOWS);
  assign load_rect = '{left: left_i, bottom: bottom_i, right: right_i, top: top_i};

  // Capture the click point
  always_ff @(posedge clk_i) begin
    if (cmd_i.point_we) begin
      px_q <= point_x_i;
      py_q <= point_y_i;
    end
  end

  // Compare every position in use against the point, edges inclusive
  always_comb begin
    for (int p = 1; p <= MAX_WINDOWS; p++) begin
      match[p] = (p <= int'(n_top))
              && (px_q >= rect_q[p].left)   && (px_q <= rect_q[p].right)
              && (py_q >= rect_q[p].bottom) && (py_q <= rect_q[p].top);
    end
  end

  // Pick the highest matching position
  always_comb begin
    found_d = 1'b0;
    pos_d   = '0;
    for (int p = 1; p <= MAX_WINDOWS; p++) begin
      if (match[p]) begin
        found_d = 1'b1;
        pos_d   = POS_W'(p);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q <= 1'b0;
    end else if (cmd_i.search_en) begin
      found_q <= found_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.search_en) begin
      pos_q <= pos_d;
    end
  end

  // Entry that moves to the top
  assign saved_rect = rect_q[pos_q];
  assign saved_id   = id_q[pos_q];

  // Per-position storage: load, shift down, or take the moved entry
  for (genvar k = 1; k <= MAX_WINDOWS; k++) begin : g_entry
    rect_t rect_d;
    pos_t  id_d;
    rect_t upper_rect;
    pos_t  upper_id;

    if (k < MAX_WINDOWS) begin : g_upper
      assign upper_rect = rect_q[k+1];
      assign upper_id   = id_q[k+1];
    end else begin : g_last
      assign upper_rect = rect_q[k];
      assign upper_id   = id_q[k];
    end

    always_comb begin
      rect_d = rect_q[k];
      id_d   = id_q[k];
      priority if (cmd_i.load_we && slot_ok && (int'(slot_i) == k)) begin
        rect_d = load_rect;
        id_d   = POS_W'(k);
      end else if (cmd_i.shift_en && found_q && (k == int'(n_top))) begin
        rect_d = saved_rect;
        id_d   = saved_id;
      end else if (cmd_i.shift_en && found_q && (k >= int'(pos_q)) && (k < int'(n_top))) begin
        rect_d = upper_rect;
        id_d   = upper_id;
      end else begin
        rect_d = rect_q[k];
        id_d   = id_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      rect_q[k] <= rect_d;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        id_q[k] <= POS_W'(k);
      end else begin
        id_q[k] <= id_d;
      end
    end
  end

  // Result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.shift_en) begin
      hit_q    <= found_q;
      win_id_q <= found_q ? ID_OUT_W'(saved_id) : '0;
    end
  end

  assign hit_o       = hit_q;
  assign window_id_o = win_id_q;

endmodule

/* sv/window_stack_hit_test.sv */
// Window z-order stack with click hit test and move to front.
// A load item is written into its slot when it is accepted; the next item may
// follow in the next cycle. A click item blocks new items while it is compared in
// the search state and moved to the top in the shift state; its result is registered.
// Reset clears the controller, sets window_count to 1 and each position's
// window number to its own position; rectangles are undefined until loaded.
module window_stack_hit_test (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic                           command_i,
  input  logic [wsh_pkg::SLOT_W-1:0]     slot_i,
  input  wsh_pkg::coord_t                left_i,
  input  wsh_pkg::coord_t                bottom_i,
  input  wsh_pkg::coord_t                right_i,
  input  wsh_pkg::coord_t                top_i,
  input  wsh_pkg::coord_t                point_x_i,
  input  wsh_pkg::coord_t                point_y_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic                           hit_o,
  output logic [wsh_pkg::ID_OUT_W-1:0]   window_id_o,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [wsh_pkg::APB_AW-1:0]     paddr,
  input  logic [wsh_pkg::APB_DW-1:0]     pwdata,
  output logic [wsh_pkg::APB_DW-1:0]     prdata,
  output logic                           pready
);
  import wsh_pkg::*;

  logic [CNT_W-1:0] window_count_q;
  wsh_cmd_t         cmd;
  logic             reg_sel;

  // Register file: window_count at byte address 0
  assign pready  = 1'b1;
  assign reg_sel = (paddr[APB_AW-1] == REG_WINDOW_COUNT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_count_q <= CNT_W'(1);
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      window_count_q <= pwdata[CNT_W-1:0];
    end
  end

  assign prdata = reg_sel ? APB_DW'(window_count_q) : '0;

  wsh_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .command_i   (command_i),
    .out_ready_i (out_ready_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .cmd_o       (cmd)
  );

  wsh_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .window_count_i (window_count_q),
    .slot_i         (slot_i),
    .left_i         (left_i),
    .bottom_i       (bottom_i),
    .right_i        (right_i),
    .top_i          (top_i),
    .point_x_i      (point_x_i),
    .point_y_i      (point_y_i),
    .hit_o          (hit_o),
    .window_id_o    (window_id_o)
  );

endmodule

/* sv/wsh_checker.sv */
module wsh_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           in_valid_i,
  input logic                           in_ready_o,
  input logic                           command_i,
  input logic                           out_valid_o,
  input logic                           out_ready_i,
  input logic                           hit_o,
  input logic [wsh_pkg::ID_OUT_W-1:0]   window_id_o
);
  import wsh_pkg::*;

  // A click item blocks new items while it is compared and shifted
  a_click_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && command_i == CMD_CLICK) |=> !in_ready_o ##1 !in_ready_o)
    else $error("item accepted while a click is in progress");

  // A load item produces no result
  a_load_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && command_i == CMD_LOAD && !out_valid_o) |=> !out_valid_o)
    else $error("result appeared after a load item");

  // A miss reports window zero, a hit a real window
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !hit_o) |-> (window_id_o == '0))
    else $error("ignored click carries a window number");

  a_hit_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && hit_o) |-> (window_id_o != '0))
    else $error("hit reports window zero");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=>
      (out_valid_o && $stable(hit_o) && $stable(window_id_o)))
    else $error("stalled result changed");

endmodule

bind window_stack_hit_test wsh_checker u_wsh_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .command_i   (command_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .hit_o       (hit_o),
  .window_id_o (window_id_o)
);

/* tb/sv/tb_window_stack_hit_test.sv */
module tb_window_stack_hit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import wsh_pkg::*;

  localparam int SETTLE_CYCLES  = 8;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLD_OFF_LEN   = 300;
  localparam int MAX_REPORTS    = 10;
  localparam logic [APB_AW-1:0] WINDOW_COUNT_ADDR = APB_AW'(4 * REG_WINDOW_COUNT);

  typedef struct {
    logic              command;
    logic [SLOT_W-1:0] slot;
    rect_t             rect;
    coord_t            point_x;
    coord_t            point_y;
  } stack_item_t;

  typedef struct {
    logic                hit;
    logic [ID_OUT_W-1:0] window_id;
  } click_result_t;

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                in_valid_i  = 1'b0;
  logic                in_ready_o;
  logic                command_i   = CMD_LOAD;
  logic [SLOT_W-1:0]   slot_i      = '0;
  coord_t              left_i      = '0;
  coord_t              bottom_i    = '0;
  coord_t              right_i     = '0;
  coord_t              top_i       = '0;
  coord_t              point_x_i   = '0;
  coord_t              point_y_i   = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  logic                hit_o;
  logic [ID_OUT_W-1:0] window_id_o;
  logic                psel        = 1'b0;
  logic                penable     = 1'b0;
  logic                pwrite      = 1'b0;
  logic [APB_AW-1:0]   paddr       = '0;
  logic [APB_DW-1:0]   pwdata      = '0;
  logic [APB_DW-1:0]   prdata;
  logic                pready;

  // Shadow of the window stack and of the count register
  rect_t               pos_rect [1:MAX_WINDOWS];
  logic [ID_OUT_W-1:0] pos_id   [1:MAX_WINDOWS];
  logic [CNT_W-1:0]    stack_depth;
  click_result_t       expected_clicks [$];

  int mismatch_count = 0;
  int send_gap_pct   = 0;
  int recv_stall_pct = 0;
  int hold_off_left  = 0;
  int quiet_cycles   = 0;

  window_stack_hit_test DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .command_i   (command_i),
    .slot_i      (slot_i),
    .left_i      (left_i),
    .bottom_i    (bottom_i),
    .right_i     (right_i),
    .top_i       (top_i),
    .point_x_i   (point_x_i),
    .point_y_i   (point_y_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .hit_o       (hit_o),
    .window_id_o (window_id_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic void report_mismatch(string what, int unsigned want, int unsigned got);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) begin
      $display("%0t: mismatch on %s: expected %0d, got %0d", $realtime, what, want, got);
    end
  endfunction

  // Positions searched by a click: the count saturates at the stack size
  function automatic int search_depth();
    return (stack_depth > MAX_WINDOWS) ? MAX_WINDOWS : int'(stack_depth);
  endfunction

  // Update the shadow stack with one accepted item, queue the click result
  function automatic void apply_item(input stack_item_t it);
    click_result_t       res;
    rect_t               moved_rect;
    logic [ID_OUT_W-1:0] moved_id;
    int                  n;
    if (it.command == CMD_LOAD) begin
      if (it.slot >= 1 && it.slot <= MAX_WINDOWS) begin
        pos_rect[it.slot] = it.rect;
        pos_id[it.slot]   = it.slot;
      end
      return;
    end
    n = search_depth();
    res.hit       = 1'b0;
    res.window_id = '0;
    for (int p = n; p >= 1; p--) begin
      if (it.point_x >= pos_rect[p].left && it.point_x <= pos_rect[p].right &&
          it.point_y >= pos_rect[p].bottom && it.point_y <= pos_rect[p].top) begin
        res.hit       = 1'b1;
        res.window_id = pos_id[p];
        moved_rect    = pos_rect[p];
        moved_id      = pos_id[p];
        // Raise the hit window, drop the ones above it by one
        for (int k = p; k < n; k++) begin
          pos_rect[k] = pos_rect[k+1];
          pos_id[k]   = pos_id[k+1];
        end
        pos_rect[n] = moved_rect;
        pos_id[n]   = moved_id;
        break;
      end
    end
    expected_clicks.push_back(res);
  endfunction

  function automatic stack_item_t load_item(input logic [SLOT_W-1:0] slot, input rect_t r);
    stack_item_t it;
    it.command = CMD_LOAD;
    it.slot    = slot;
    it.rect    = r;
    it.point_x = coord_t'($urandom);
    it.point_y = coord_t'($urandom);
    return it;
  endfunction

  function automatic stack_item_t click_item(input coord_t x, input coord_t y);
    stack_item_t it;
    it.command = CMD_CLICK;
    it.slot    = SLOT_W'($urandom);
    it.rect    = rect_t'({$urandom, $urandom});
    it.point_x = x;
    it.point_y = y;
    return it;
  endfunction

  function automatic rect_t make_rect(input int l, input int b, input int r, input int t);
    rect_t rc;
    rc.left   = coord_t'(l);
    rc.bottom = coord_t'(b);
    rc.right  = coord_t'(r);
    rc.top    = coord_t'(t);
    return rc;
  endfunction

  // Mix of full-screen, single-pixel, inverted, small and large rectangles
  function automatic rect_t random_rect();
    int a, b, c, d, w, shape;
    a     = $urandom_range(4095);
    b     = $urandom_range(4095);
    c     = $urandom_range(4095);
    d     = $urandom_range(4095);
    w     = $urandom_range(300);
    shape = $urandom_range(99);
    if (shape < 10) begin
      return make_rect(0, 0, 4095, 4095);
    end else if (shape < 20) begin
      return make_rect(a, b, a, b);
    end else if (shape < 30) begin
      if (a == c) c = a ^ 1;
      return make_rect((a > c) ? a : c, b, (a > c) ? c : a, d);
    end else if (shape < 60) begin
      return make_rect(a, b, (a + w > 4095) ? 4095 : a + w, (b + w > 4095) ? 4095 : b + w);
    end
    return make_rect((a < c) ? a : c, (b < d) ? b : d, (a < c) ? c : a, (b < d) ? d : b);
  endfunction

  // Mostly clicks, many aimed inside a stacked window; the rest loads and stray clicks
  function automatic stack_item_t random_item();
    int    roll, p;
    rect_t r;
    roll = $urandom_range(99);
    if (roll < 30) begin
      if ($urandom_range(9) == 0) begin
        return load_item(($urandom_range(1) == 0) ? SLOT_W'(0) :
                         SLOT_W'($urandom_range(31, MAX_WINDOWS + 1)), random_rect());
      end
      return load_item(SLOT_W'($urandom_range(MAX_WINDOWS, 1)), random_rect());
    end
    if (roll < 80 && search_depth() > 0) begin
      p = $urandom_range(search_depth(), 1);
      r = pos_rect[p];
      if (r.left <= r.right && r.bottom <= r.top) begin
        return click_item(coord_t'($urandom_range(int'(r.right), int'(r.left))),
                          coord_t'($urandom_range(int'(r.top), int'(r.bottom))));
      end
    end
    return click_item(coord_t'($urandom), coord_t'($urandom));
  endfunction

  // Offer one item at a falling edge, hold it until accepted
  task automatic send_item(input stack_item_t it);
    @(negedge clk_i);
    if ($urandom_range(99) < send_gap_pct) begin
      in_valid_i <= 1'b0;
      do @(negedge clk_i); while ($urandom_range(99) < send_gap_pct);
    end
    command_i  <= it.command;
    slot_i     <= it.slot;
    left_i     <= it.rect.left;
    bottom_i   <= it.rect.bottom;
    right_i    <= it.rect.right;
    top_i      <= it.rect.top;
    point_x_i  <= it.point_x;
    point_y_i  <= it.point_y;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    apply_item(it);
  endtask

  // Stop offering items until every click result has come back
  task automatic wait_for_results();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (expected_clicks.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic apb_write(input logic [APB_DW-1:0] value);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= WINDOW_COUNT_ADDR;
    pwdata  <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    stack_depth = value[CNT_W-1:0];
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic apb_read_check(input logic [APB_DW-1:0] want);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= WINDOW_COUNT_ADDR;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== want) report_mismatch("window_count readback", want, prdata);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Write the count with noise in the unused upper bits, then read it back
  task automatic set_window_count(input int count);
    logic [APB_DW-1:0] value;
    value = {$urandom} & ~APB_DW'((1 << CNT_W) - 1) | APB_DW'(count);
    apb_write(value);
    apb_read_check(APB_DW'(value[CNT_W-1:0]));
  endtask

  task automatic test_register_reset();
    apb_read_check(APB_DW'(1));
  endtask

  // Count of zero: nothing is searched, so clicks are ignored even before loads
  task automatic test_empty_stack();
    set_window_count(0);
    send_item(click_item(12'h000, 12'h000));
    send_item(click_item(12'hFFF, 12'hFFF));
    wait_for_results();
  endtask

  // Fill every position: full screen at the bottom, an inverted one, two single
  // corner pixels, the rest in the middle of the screen
  task automatic test_load_stack();
    send_item(load_item(SLOT_W'(1), make_rect(0, 0, 4095, 4095)));
    send_item(load_item(SLOT_W'(2), make_rect(100, 0, 50, 4095)));
    send_item(load_item(SLOT_W'(3), make_rect(4095, 4095, 4095, 4095)));
    send_item(load_item(SLOT_W'(4), make_rect(0, 0, 0, 0)));
    for (int s = 5; s <= MAX_WINDOWS; s++) begin
      send_item(load_item(SLOT_W'(s), make_rect($urandom_range(2000, 1000),
        $urandom_range(2000, 1000), $urandom_range(3000, 2000), $urandom_range(3000, 2000))));
    end
  endtask

  // Loads to slot zero or past the stack must leave it untouched
  task automatic test_ignored_loads();
    send_item(load_item(SLOT_W'(0), make_rect(0, 0, 4095, 4095)));
    send_item(load_item(SLOT_W'(31), make_rect(0, 0, 4095, 4095)));
  endtask

  // Corner hits, a click inside the span of an inverted rectangle,
  // a count above the stack size and a count of one
  task automatic test_directed_clicks();
    wait_for_results();
    set_window_count(MAX_WINDOWS);
    send_item(click_item(12'hFFF, 12'hFFF));
    send_item(click_item(12'h000, 12'h000));
    send_item(click_item(coord_t'(75), coord_t'(4000)));
    wait_for_results();
    set_window_count(31);
    send_item(click_item(12'hFFF, 12'hFFF));
    wait_for_results();
    set_window_count(1);
    send_item(click_item(coord_t'(2000), coord_t'(2000)));
    wait_for_results();
  endtask

  // Random traffic in segments, each under a fresh window count
  task automatic test_random_traffic(input int items, input int gap_pct, input int stall_pct);
    int sent, seg, roll;
    send_gap_pct   = gap_pct;
    recv_stall_pct = stall_pct;
    sent = 0;
    while (sent < items) begin
      wait_for_results();
      roll = $urandom_range(99);
      if (roll < 5) set_window_count(0);
      else if (roll < 15) set_window_count($urandom_range(31, MAX_WINDOWS + 1));
      else set_window_count($urandom_range(MAX_WINDOWS, 1));
      seg = $urandom_range(60, 30);
      for (int i = 0; i < seg; i++) send_item(random_item());
      sent += seg;
    end
    wait_for_results();
  endtask

  // Hold the result side off while items keep coming, so the input stalls
  task automatic test_backpressure();
    wait_for_results();
    set_window_count(MAX_WINDOWS);
    send_gap_pct   = 0;
    recv_stall_pct = 0;
    hold_off_left  = HOLD_OFF_LEN;
    for (int i = 0; i < 24; i++) send_item(random_item());
    wait_for_results();
  endtask

  // Result side: random stalls, or a long hold-off when one is pending
  always @(negedge clk_i) begin
    if (hold_off_left > 0) begin
      out_ready_i   <= 1'b0;
      hold_off_left  = hold_off_left - 1;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Compare each accepted result with the oldest expected click
  always @(posedge clk_i) begin : check_results
    click_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_clicks.size() == 0) begin
        report_mismatch("result with nothing expected, window_id", 0, window_id_o);
      end else begin
        want = expected_clicks.pop_front();
        if (hit_o !== want.hit) report_mismatch("hit", want.hit, hit_o);
        if (window_id_o !== want.window_id) begin
          report_mismatch("window_id", want.window_id, window_id_o);
        end
      end
    end
  end

  // End the run when nothing moves for too long
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet_cycles = 0;
    else quiet_cycles = quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_window_stack_hit_test NOT OK");
      $finish;
    end
  end

  initial begin
    stack_depth = CNT_W'(1);
    for (int p = 1; p <= MAX_WINDOWS; p++) begin
      pos_id[p]   = ID_OUT_W'(p);
      pos_rect[p] = '0;
    end
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;

    test_register_reset();
    test_empty_stack();
    test_load_stack();
    test_ignored_loads();
    test_directed_clicks();
    test_random_traffic(265, 16, 65);
    test_random_traffic(265, 65, 16);
    test_backpressure();
    test_random_traffic(265, 0, 0);

    wait_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0 && expected_clicks.size() == 0) begin
      $display("tb_window_stack_hit_test OK");
    end else begin
      $display("tb_window_stack_hit_test NOT OK");
    end
    $finish;
  end

endmodule
